/* rtl/mvpid_pkg.sv */
// ----------------------------------------------------------------------------
// mvpid_pkg: shared types and constants of the velocity PID block
// Register indexes, request codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mvpid_pkg;

   localparam int DefaultNumChannels = 4;

   localparam logic [1:0] REQ_COMPUTE = 2'd0;
   localparam logic [1:0] REQ_INIT    = 2'd1;
   localparam logic [1:0] REQ_RESET   = 2'd2;

   localparam logic [2:0] CSR_KP      = 3'd0;
   localparam logic [2:0] CSR_KI      = 3'd1;
   localparam logic [2:0] CSR_KD      = 3'd2;
   localparam logic [2:0] CSR_PERIOD  = 3'd3;
   localparam logic [2:0] CSR_THRESH  = 3'd4;
   localparam logic [2:0] CSR_IMAX    = 3'd5;
   localparam logic [2:0] CSR_OUT_MIN = 3'd6;
   localparam logic [2:0] CSR_OUT_MAX = 3'd7;

   localparam logic [1:0] MUL_ERR_SP = 2'd0;
   localparam logic [1:0] MUL_KP_ERR = 2'd1;
   localparam logic [1:0] MUL_KI_INT = 2'd2;
   localparam logic [1:0] MUL_KD_DIF = 2'd3;

   localparam int DivSteps = 64;

   typedef struct packed {
      logic       load;
      logic       mul_go;
      logic [1:0] mul_sel;
      logic       upd_integ;
      logic       cap_p;
      logic       cap_i;
      logic       div_start;
      logic       div_step;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic compute_ok;
      logic div_done;
   } sts_type;

endpackage

/* rtl/multichannel_velocity_pid.sv */
// ----------------------------------------------------------------------------
// multichannel_velocity_pid: Q16.16 PID speed loop for several motors
//
// Request stream req_*: one transfer carries a request kind, a channel and
// the target and measured speeds. Each request yields exactly one result
// transfer on rsp_*: the clamped drive, the speed error and a status flag.
// Settings are written through csr_*; the user must write them only while
// the block is idle, which the block itself does not enforce. A compute
// makes four passes through one shared 33x33 multiplier, then a
// one-bit-per-cycle 64-step divide of the derivative term by the period.
// One request is in work at a time; the next is taken once a result is
// registered, even while that result waits for rsp_tready. A stalled
// result holds the block in its final step until it is taken.
// Synchronous reset clears settings to defaults and all channels to not
// initialized with zero history; no result is pending after reset.
// ----------------------------------------------------------------------------
module multichannel_velocity_pid
   import mvpid_pkg::*;
#(
   parameter int NUM_CHANNELS = DefaultNumChannels
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // target, measured
   input  logic [3:0]  req_tuser,   // req_type, channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // drive_output, speed_error
   output logic        rsp_tuser,   // status
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   mvpid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   mvpid_dp #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_kind     (req_tuser[1:0]),
      .req_chan     (req_tuser[3:2]),
      .req_target   (req_tdata[31:0]),
      .req_measured (req_tdata[63:32]),
      .rsp_drive    (rsp_tdata[31:0]),
      .rsp_err      (rsp_tdata[63:32]),
      .rsp_status   (rsp_tuser),
      .cmd          (cmd),
      .sts          (sts)
   );

endmodule

/* rtl/mvpid_ctrl.sv */
// ----------------------------------------------------------------------------
// mvpid_ctrl: sequencer of the velocity PID block
// Steps the shared multiplier and the divider and owns the result valid.
// ----------------------------------------------------------------------------
module mvpid_ctrl
   import mvpid_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_M1     = 4'd2;
   localparam logic [3:0] S_M2     = 4'd3;
   localparam logic [3:0] S_M3     = 4'd4;
   localparam logic [3:0] S_M4     = 4'd5;
   localparam logic [3:0] S_DIV0   = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_FIN    = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      valid_in = valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: state_in = sts.compute_ok ? S_M1 : S_FIN;
         S_M1: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_ERR_SP;
            state_in    = S_M2;
         end
         S_M2: begin
            cmd.upd_integ = 1'b1;
            cmd.mul_go    = 1'b1;
            cmd.mul_sel   = MUL_KP_ERR;
            state_in      = S_M3;
         end
         S_M3: begin
            cmd.cap_p   = 1'b1;
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_KI_INT;
            state_in    = S_M4;
         end
         S_M4: begin
            cmd.cap_i   = 1'b1;
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_KD_DIF;
            state_in    = S_DIV0;
         end
         S_DIV0: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_FIN;
            else cmd.div_step = 1'b1;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               valid_in   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

/* rtl/mvpid_dp.sv */
// ----------------------------------------------------------------------------
// mvpid_dp: datapath of the velocity PID block
// Settings registers, channel state, shared multiplier, radix-2 divider.
// ----------------------------------------------------------------------------
module mvpid_dp
   import mvpid_pkg::*;
#(
   parameter int NUM_CHANNELS = DefaultNumChannels
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic [1:0]  req_kind,
   input  logic [1:0]  req_chan,
   input  logic [31:0] req_target,
   input  logic [31:0] req_measured,
   output logic [31:0] rsp_drive,
   output logic [31:0] rsp_err,
   output logic        rsp_status,
   input  cmd_type     cmd,
   output sts_type     sts
);

   localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic [30:0] kp_ff, ki_ff, kd_ff, thr_ff, imax_ff, omax_ff;
   logic [16:0] sp_ff;
   logic signed [31:0] omin_ff;

   logic signed [31:0] integ_ff [NUM_CHANNELS];
   logic signed [31:0] prev_ff  [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] ready_ff;

   logic [1:0]  kind_ff;
   logic        cvalid_ff;
   logic [IdxW-1:0] idx_ff;
   logic signed [31:0] err_ff, newint_ff, p_ff, i_ff, drive_ff, erro_ff;
   logic        stat_ff;
   logic signed [65:0] mp_ff;
   logic [63:0] num_ff;
   logic [17:0] rem_ff;
   logic        neg_ff;
   logic [6:0]  cnt_ff;

   logic signed [32:0] diff33, mula, mulb, acc_lim;
   logic signed [32:0] sub33;
   logic signed [31:0] err_in;
   logic [32:0]  abs_err;
   logic signed [34:0] acc;
   logic signed [49:0] sh_p;
   logic        cvalid_in, compute_ok;
   logic [17:0] rem_sh;
   logic [63:0] qmag;
   logic signed [31:0] d_val, sum_sat, drive_in;
   logic signed [33:0] sum34;

   function automatic logic signed [31:0] sat32_50(input logic signed [49:0] v);
      if (v > 50'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -50'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= '0;
         ki_ff   <= '0;
         kd_ff   <= '0;
         sp_ff   <= 17'd655;
         thr_ff  <= 31'h7FFFFFFF;
         imax_ff <= 31'h7FFFFFFF;
         omin_ff <= -32'sd6553600;
         omax_ff <= 31'd6553600;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KP:      kp_ff   <= csr_wdata[30:0];
            CSR_KI:      ki_ff   <= csr_wdata[30:0];
            CSR_KD:      kd_ff   <= csr_wdata[30:0];
            CSR_PERIOD:  sp_ff   <= csr_wdata[16:0];
            CSR_THRESH:  thr_ff  <= csr_wdata[30:0];
            CSR_IMAX:    imax_ff <= csr_wdata[30:0];
            CSR_OUT_MIN: omin_ff <= csr_wdata;
            CSR_OUT_MAX: omax_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign sub33  = {req_target[31], req_target} - {req_measured[31], req_measured};
   assign err_in = (sub33 > 33'sd2147483647) ? 32'sh7FFFFFFF :
                   (sub33 < -33'sd2147483648) ? 32'sh80000000 : sub33[31:0];
   assign cvalid_in = ({30'd0, req_chan} < 32'(NUM_CHANNELS));

   assign compute_ok = (kind_ff == REQ_COMPUTE) && cvalid_ff && ready_ff[idx_ff] &&
                       (sp_ff != '0);
   assign sts.compute_ok = compute_ok;
   assign sts.div_done   = (cnt_ff == '0);

   assign diff33  = {err_ff[31], err_ff} - {prev_ff[idx_ff][31], prev_ff[idx_ff]};
   assign abs_err = err_ff[31] ? 33'(-{err_ff[31], err_ff}) : {1'b0, err_ff};
   assign acc     = 35'(integ_ff[idx_ff]) + 35'(mp_ff >>> 16);
   assign acc_lim = {2'b0, imax_ff};

   always_comb begin
      case (cmd.mul_sel)
         MUL_ERR_SP: begin mula = {err_ff[31], err_ff}; mulb = {16'd0, sp_ff}; end
         MUL_KP_ERR: begin mula = {2'b0, kp_ff}; mulb = {err_ff[31], err_ff}; end
         MUL_KI_INT: begin mula = {2'b0, ki_ff}; mulb = {newint_ff[31], newint_ff}; end
         default:    begin mula = {2'b0, kd_ff}; mulb = diff33; end
      endcase
   end

   assign sh_p   = 50'(mp_ff >>> 16);
   assign rem_sh = {rem_ff[16:0], num_ff[63]};

   assign qmag  = num_ff;
   always_comb begin
      if (neg_ff) d_val = (qmag > 64'd2147483648) ? 32'sh80000000 : 32'(-qmag);
      else        d_val = (qmag > 64'd2147483647) ? 32'sh7FFFFFFF : qmag[31:0];
   end
   assign sum34   = 34'(p_ff) + 34'(i_ff) + 34'(d_val);
   assign sum_sat = (sum34 > 34'sd2147483647) ? 32'sh7FFFFFFF :
                    (sum34 < -34'sd2147483648) ? 32'sh80000000 : sum34[31:0];
   assign drive_in = (sum_sat > $signed({1'b0, omax_ff})) ? $signed({1'b0, omax_ff}) :
                     (sum_sat < omin_ff) ? omin_ff : sum_sat;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         cvalid_ff <= cvalid_in;
         idx_ff    <= IdxW'(req_chan);
         err_ff    <= err_in;
      end
      if (cmd.mul_go) mp_ff <= mula * mulb;
      if (cmd.upd_integ) begin
         if (abs_err < {2'b0, thr_ff}) begin
            if (acc > 35'(acc_lim))       newint_ff <= {1'b0, imax_ff};
            else if (acc < -35'(acc_lim)) newint_ff <= 32'(-acc_lim);
            else                          newint_ff <= acc[31:0];
         end else begin
            newint_ff <= integ_ff[idx_ff];
         end
      end
      if (cmd.cap_p) p_ff <= sat32_50(sh_p);
      if (cmd.cap_i) i_ff <= sat32_50(sh_p);
      if (cmd.div_start) begin
         neg_ff <= mp_ff[65];
         num_ff <= mp_ff[65] ? 64'(-mp_ff) : mp_ff[63:0];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, sp_ff}) begin
            rem_ff <= rem_sh - {1'b0, sp_ff};
            num_ff <= {num_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            num_ff <= {num_ff[62:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         drive_ff <= compute_ok ? drive_in : '0;
         erro_ff  <= compute_ok ? err_ff : '0;
         stat_ff  <= (kind_ff == REQ_COMPUTE) && !(cvalid_ff && ready_ff[idx_ff]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else if (cmd.div_start) cnt_ff <= 7'(DivSteps);
      else if (cmd.div_step) cnt_ff <= cnt_ff - 7'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= '0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            integ_ff[c] <= '0;
            prev_ff[c]  <= '0;
         end
      end else if (cmd.finish) begin
         if ((kind_ff == REQ_INIT || kind_ff == REQ_RESET) && cvalid_ff) begin
            integ_ff[idx_ff] <= '0;
            prev_ff[idx_ff]  <= '0;
            if (kind_ff == REQ_INIT) ready_ff[idx_ff] <= 1'b1;
         end else if (compute_ok) begin
            integ_ff[idx_ff] <= newint_ff;
            prev_ff[idx_ff]  <= err_ff;
         end
      end
   end

   assign rsp_drive  = drive_ff;
   assign rsp_err    = erro_ff;
   assign rsp_status = stat_ff;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for multichannel_velocity_pid
// Requests are queued by a stimulus process and driven by a clocked driver;
// a clocked monitor checks every response against a behavioral PID model
// run at request acceptance. Settings change only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
   import mvpid_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  chan;
      logic [31:0] target;
      logic [31:0] measured;
   } pid_req_type;

   typedef struct packed {
      logic [31:0] drive;
      logic [31:0] err;
      logic        status;
   } pid_rsp_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   multichannel_velocity_pid i_dut (.*);

   initial forever #4 clock = ~clock;

   pid_req_type pending_reqs[$];
   pid_rsp_type expected_rsps[$];
   int       error_count = 0;
   bit       calm = 0;
   bit       hold_rx = 0;
   int       tx_gap = 0;
   int       rx_gap = 0;

   // model state
   logic [30:0] m_kp, m_ki, m_kd, m_thresh, m_imax, m_omax;
   logic [16:0] m_period;
   logic signed [31:0] m_omin;
   logic signed [31:0] m_integ[4];
   logic signed [31:0] m_prev[4];
   bit m_ready[4];

   function automatic logic signed [31:0] sat32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic pid_rsp_type pid_predict(pid_req_type r);
      pid_rsp_type o;
      logic signed [31:0] e, p, it, d;
      logic signed [63:0] ae, acc, lim, df, s;
      o = '0;
      if (r.kind == REQ_INIT || r.kind == REQ_RESET) begin
         m_integ[r.chan] = 0;
         m_prev[r.chan] = 0;
         if (r.kind == REQ_INIT) m_ready[r.chan] = 1;
      end else if (r.kind == REQ_COMPUTE) begin
         if (!m_ready[r.chan]) begin
            o.status = 1;
         end else if (m_period != 0) begin
            e = sat32($signed({{32{r.target[31]}}, r.target})
                      - $signed({{32{r.measured[31]}}, r.measured}));
            ae = (e < 0) ? -64'(e) : 64'(e);
            if (ae < $signed({33'd0, m_thresh})) begin
               acc = 64'(m_integ[r.chan]) + ((64'(e) * $signed({47'd0, m_period})) >>> 16);
               lim = $signed({33'd0, m_imax});
               if (acc > lim) acc = lim;
               if (acc < -lim) acc = -lim;
               m_integ[r.chan] = acc[31:0];
            end
            p = sat32(($signed({33'd0, m_kp}) * 64'(e)) >>> 16);
            it = sat32(($signed({33'd0, m_ki}) * 64'(m_integ[r.chan])) >>> 16);
            df = 64'(e) - 64'(m_prev[r.chan]);
            d = sat32(($signed({33'd0, m_kd}) * df) / $signed({47'd0, m_period}));
            s = 64'(sat32(64'(p) + 64'(it) + 64'(d)));
            if (s > $signed({33'd0, m_omax})) s = {33'd0, m_omax};
            else if (s < 64'(m_omin)) s = 64'(m_omin);
            o.drive = s[31:0];
            o.err = e;
            m_prev[r.chan] = e;
         end
      end
      return o;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) expected_rsps.push_back(pid_predict(pending_reqs.pop_front()));
         if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            req_tvalid <= 0;
         end else if (pending_reqs.size() > 0) begin
            pid_req_type n;
            n = pending_reqs[0];
            req_tvalid <= 1;
            req_tdata <= {n.measured, n.target};
            req_tuser <= {n.chan, n.kind};
            if (!calm && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 12);
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               report("unexpected transfer", rsp_tdata[31:0], 0);
            end else begin
               pid_rsp_type w;
               w = expected_rsps.pop_front();
               if (rsp_tdata[31:0] !== w.drive) report("drive", rsp_tdata[31:0], w.drive);
               if (rsp_tdata[63:32] !== w.err) report("error", rsp_tdata[63:32], w.err);
               if (rsp_tuser !== w.status)
                  report("status", 32'(rsp_tuser), 32'(w.status));
            end
         end
         if (hold_rx) begin
            rsp_tready <= 0;
         end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
            if (!calm && $urandom_range(0, 9) == 0) rx_gap <= $urandom_range(1, 12);
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_KP:      m_kp = val[30:0];
         CSR_KI:      m_ki = val[30:0];
         CSR_KD:      m_kd = val[30:0];
         CSR_PERIOD:  m_period = val[16:0];
         CSR_THRESH:  m_thresh = val[30:0];
         CSR_IMAX:    m_imax = val[30:0];
         CSR_OUT_MIN: m_omin = val;
         default:     m_omax = val[30:0];
      endcase
   endtask

   task automatic drain;
      wait (pending_reqs.size() == 0 && !req_tvalid && expected_rsps.size() == 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic push_req(logic [1:0] k, logic [1:0] c, logic [31:0] t, logic [31:0] m);
      pid_req_type r;
      r.kind = k; r.chan = c; r.target = t; r.measured = m;
      pending_reqs.push_back(r);
   endtask

   function automatic logic [31:0] rnd_speed();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 2000000) - 1000000;
         2: return $urandom_range(0, 100) - 50;
         default: return {$urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff};
      endcase
   endfunction

   task automatic random_settings(bit extreme);
      csr_write(CSR_KP, extreme ? 32'h7fffffff : $urandom_range(0, 32'h40000));
      csr_write(CSR_KI, extreme ? 32'h7fffffff : $urandom_range(0, 32'h20000));
      csr_write(CSR_KD, extreme ? 32'h7fffffff : $urandom_range(0, 32'h10000));
      csr_write(CSR_PERIOD, extreme ? 32'h10000 : $urandom_range(1, 32'h1ffff));
      csr_write(CSR_THRESH, $urandom_range(0, 3) == 0 ? 0 : $urandom);
      csr_write(CSR_IMAX, $urandom_range(0, 1) ? 32'h7fffffff : $urandom_range(0, 32'h1000000));
      csr_write(CSR_OUT_MIN, extreme ? 32'h80000000 : -$urandom_range(0, 32'h1000000));
      csr_write(CSR_OUT_MAX, extreme ? 32'h7fffffff : $urandom_range(0, 32'h1000000));
   endtask

   initial begin
      int ph;
      m_kp = 0; m_ki = 0; m_kd = 0; m_period = 655;
      m_thresh = '1; m_imax = '1; m_omin = -6553600; m_omax = 6553600;
      for (int i = 0; i < 4; i++) begin
         m_integ[i] = 0; m_prev[i] = 0; m_ready[i] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 0;
      // directed: uninitialized compute, type three, init, extremes
      push_req(REQ_COMPUTE, 0, 32'h10000, 0);
      push_req(2'd3, 1, 32'hffffffff, 32'hffffffff);
      push_req(REQ_RESET, 2, 0, 0);
      for (int c = 0; c < 4; c++) push_req(REQ_INIT, 2'(c), 0, 0);
      push_req(REQ_COMPUTE, 0, 32'h7fffffff, 32'h80000000);
      push_req(REQ_COMPUTE, 1, 32'h80000000, 32'h7fffffff);
      push_req(REQ_COMPUTE, 2, 32'h00010000, 32'h0);
      push_req(REQ_COMPUTE, 3, 32'h0, 32'h0);
      drain();
      random_settings(1);
      push_req(REQ_COMPUTE, 0, 32'h7fffffff, 32'h80000000);
      push_req(REQ_COMPUTE, 1, 32'h80000000, 32'h7fffffff);
      push_req(REQ_RESET, 0, 0, 0);
      push_req(REQ_COMPUTE, 0, 32'h12345678, 32'hfedcba98);
      drain();
      csr_write(CSR_PERIOD, 0);
      push_req(REQ_COMPUTE, 2, 32'h1000, 0);
      drain();
      csr_write(CSR_THRESH, 0);
      csr_write(CSR_PERIOD, 1);
      csr_write(CSR_OUT_MIN, 32'h00100000);
      csr_write(CSR_OUT_MAX, 32'h00010000);
      push_req(REQ_COMPUTE, 3, 32'h5000, 32'h1000);
      push_req(REQ_COMPUTE, 3, 32'hffff0000, 32'h1000);
      drain();
      // random phases
      for (ph = 0; ph < 9; ph++) begin
         random_settings(ph == 4);
         if (ph == 8) calm = 1;
         if (ph == 2) begin
            hold_rx = 1;
         end
         for (int n = 0; n < 100; n++) begin
            int sel;
            sel = $urandom_range(0, 19);
            if (sel == 0) push_req(REQ_INIT, 2'($urandom), rnd_speed(), rnd_speed());
            else if (sel == 1) push_req(REQ_RESET, 2'($urandom), rnd_speed(), rnd_speed());
            else if (sel == 2) push_req(2'd3, 2'($urandom), rnd_speed(), rnd_speed());
            else push_req(REQ_COMPUTE, 2'($urandom), rnd_speed(), rnd_speed());
         end
         if (ph == 2) begin
            repeat (600) @(posedge clock);
            hold_rx = 0;
         end
         drain();
      end
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #8000000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
